// File: design/sfsd_pkg.sv
// ----------------------------------------------------------------------------
// sfsd_pkg
// Shared types and constants of the sensor frame sync decoder: the request
// payloads, the configuration register indexes and the frame layout.
// ----------------------------------------------------------------------------
package sfsd_pkg;

    // Frame length in bytes, header included (legal range 8 to 31).
    localparam int unsigned FRAME_LENGTH = 16;

    // Width of the byte position counter.
    localparam int unsigned POS_W = 5;

    // Configuration register indexes.
    localparam logic CFG_SYNC_FIRST  = 1'b0;
    localparam logic CFG_SYNC_SECOND = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAB;
    localparam logic [7:0] SYNC_SECOND_RST = 8'hCD;

    // Input command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Result kind codes.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    // Byte positions with a meaning of their own.
    localparam logic [POS_W-1:0] POS_HUNT   = 5'd0;
    localparam logic [POS_W-1:0] POS_SECOND = 5'd1;
    localparam logic [POS_W-1:0] POS_X_HI   = 5'd2;
    localparam logic [POS_W-1:0] POS_X_LO   = 5'd3;
    localparam logic [POS_W-1:0] POS_Y_HI   = 5'd4;
    localparam logic [POS_W-1:0] POS_Y_LO   = 5'd5;
    localparam logic [POS_W-1:0] POS_Z_HI   = 5'd6;
    localparam logic [POS_W-1:0] POS_Z_LO   = 5'd7;
    localparam logic [POS_W-1:0] POS_END    = POS_W'(FRAME_LENGTH);

    // Input request payload.
    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_req;

    // Result request payload.
    typedef struct packed {
        logic               kind;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic        [15:0] frame_count;
    } t_out_req;

    // Header sync bytes handed to the parser.
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
    } t_sync_cfg;

endpackage

// File: design/sfsd_parser.sv
// ----------------------------------------------------------------------------
// sfsd_parser
// Per-byte frame parser: header hunt, value assembly and the saturating
// frame counter. Produces at most one result for each accepted request.
// ----------------------------------------------------------------------------
module sfsd_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  sfsd_pkg::t_in_req   i_req,
    input  sfsd_pkg::t_sync_cfg i_cfg,
    output logic                o_res_valid,
    output sfsd_pkg::t_out_req  o_res
);

    logic [sfsd_pkg::POS_W-1:0] r_pos;
    logic [sfsd_pkg::POS_W-1:0] n_pos;
    logic [15:0]                r_x;
    logic [15:0]                n_x;
    logic [15:0]                r_y;
    logic [15:0]                n_y;
    logic [15:0]                r_z;
    logic [15:0]                n_z;
    logic [15:0]                r_count;
    logic [15:0]                n_count;
    logic [sfsd_pkg::POS_W-1:0] pos_inc;
    logic [15:0]                count_inc;

    assign pos_inc   = r_pos + 1'b1;
    assign count_inc = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;

    // Next state and result for the request at the input.
    always_comb begin
        n_pos       = r_pos;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_count     = r_count;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_req.cmd == sfsd_pkg::CMD_TICK) begin
            // Report the count and clear it; frame progress is kept.
            o_res_valid       = 1'b1;
            o_res.kind        = sfsd_pkg::KIND_COUNT;
            o_res.frame_count = r_count;
            n_count           = '0;
        end else if (r_pos == sfsd_pkg::POS_HUNT) begin
            if (i_req.rx_byte == i_cfg.sync_first) begin
                n_pos = sfsd_pkg::POS_SECOND;
            end
        end else if (r_pos == sfsd_pkg::POS_SECOND) begin
            // A mismatch drops the byte and restarts the hunt.
            n_pos = (i_req.rx_byte == i_cfg.sync_second) ? sfsd_pkg::POS_X_HI
                                                         : sfsd_pkg::POS_HUNT;
        end else begin
            case (r_pos)
                sfsd_pkg::POS_X_HI: n_x[15:8] = i_req.rx_byte;
                sfsd_pkg::POS_X_LO: n_x[7:0]  = i_req.rx_byte;
                sfsd_pkg::POS_Y_HI: n_y[15:8] = i_req.rx_byte;
                sfsd_pkg::POS_Y_LO: n_y[7:0]  = i_req.rx_byte;
                sfsd_pkg::POS_Z_HI: n_z[15:8] = i_req.rx_byte;
                sfsd_pkg::POS_Z_LO: n_z[7:0]  = i_req.rx_byte;
                default: ;
            endcase
            n_pos = pos_inc;
            // End of frame: emit the values and count the frame.
            if (pos_inc >= sfsd_pkg::POS_END || pos_inc == sfsd_pkg::POS_HUNT) begin
                n_pos             = sfsd_pkg::POS_HUNT;
                n_count           = count_inc;
                o_res_valid       = 1'b1;
                o_res.kind        = sfsd_pkg::KIND_FRAME;
                o_res.accel_x     = n_x;
                o_res.accel_y     = n_y;
                o_res.accel_z     = n_z;
                o_res.frame_count = count_inc;
            end
        end
    end

    // State registers advance on each accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= sfsd_pkg::POS_HUNT;
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_count <= '0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
            r_count <= n_count;
        end
    end

endmodule

// File: design/sfsd_out_buf.sv
// ----------------------------------------------------------------------------
// sfsd_out_buf
// Two-entry result buffer. The head entry drives the output channel; the
// second entry lets the parser take one more request while the receiver
// stalls.
// ----------------------------------------------------------------------------
module sfsd_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfsd_pkg::t_out_req i_data,
    output logic               o_space,
    output logic               o_valid,
    input  logic               i_ready,
    output sfsd_pkg::t_out_req o_data
);

    logic [1:0]         r_cnt;
    logic [1:0]         n_cnt;
    sfsd_pkg::t_out_req r_d0;
    sfsd_pkg::t_out_req n_d0;
    sfsd_pkg::t_out_req r_d1;
    sfsd_pkg::t_out_req n_d1;
    logic               pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_d0;
    assign o_space = (r_cnt != 2'd2);
    assign pop     = o_valid && i_ready;

    // Queue update: a pop shifts the second entry forward.
    always_comb begin
        n_cnt = r_cnt;
        n_d0  = r_d0;
        n_d1  = r_d1;
        if (pop) begin
            n_d0  = r_d1;
            n_cnt = n_cnt - 2'd1;
        end
        if (i_push) begin
            if (n_cnt == 2'd0) begin
                n_d0 = i_data;
            end else begin
                n_d1 = i_data;
            end
            n_cnt = n_cnt + 2'd1;
        end
    end

    // Count is control state; entries are payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

endmodule

// File: design/sensor_frame_sync_decoder_core.sv
// ----------------------------------------------------------------------------
// sensor_frame_sync_decoder_core
// Header-synchronized fixed-length frame parser for a received byte stream.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): each request is either
// a received byte or a period tick. The parser hunts for the two sync bytes,
// collects the rest of the frame and, on its last byte, issues one result
// with three big-endian signed values and the frame count. A tick issues a
// result with the frame count and clears the count.
// Output channel (o_out_valid / i_out_ready / o_out_data) carries results.
// Configuration port (i_cfg_we / i_cfg_index / i_cfg_data) writes the sync
// byte chosen by i_cfg_index; write it only while the block is idle.
// Each result is registered in the result buffer on its way to the output.
// Throughput: one request per cycle while o_in_ready is high.
// A two-entry result buffer keeps requests flowing while the receiver stalls
// until a second result is waiting; with both entries full, o_in_ready stays
// low until the cycle after one is taken.
// Reset clears the parser to the hunt state, the frame count to zero, the
// result buffer to empty and the sync bytes to 0xAB and 0xCD.
// ----------------------------------------------------------------------------
module sensor_frame_sync_decoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sfsd_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sfsd_pkg::t_out_req o_out_data,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    sfsd_pkg::t_sync_cfg r_cfg;
    sfsd_pkg::t_out_req  res;
    logic                res_valid;
    logic                accept;
    logic                space;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= sfsd_pkg::SYNC_FIRST_RST;
            r_cfg.sync_second <= sfsd_pkg::SYNC_SECOND_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sfsd_pkg::CFG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                sfsd_pkg::CFG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame parser.
    sfsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req       (i_in_data),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result buffer.
    sfsd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_data  (res),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
